@@ src/kbt_pkg.sv @@
// shared constants and types for the k-bucket routing table
// no dependencies; used by every module of the block
package kbt_pkg;

   localparam int DEF_ID_BITS     = 64;
   localparam int DEF_BUCKET_SIZE = 8;
   localparam int MAX_OUT         = 64;
   localparam int FIELD_W         = 64;
   localparam int LIMIT_W         = 7;

   // request function codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   // per-cycle command to a sorting chain
   typedef struct packed {
      logic clear;
      logic ins;
      logic pop;
   } cell_ctl_type;

endpackage

@@ src/kbt_cell.sv @@
// one cell of a sorted insertion chain: holds a key and an id
// depends on kbt_pkg
module kbt_cell #(
   parameter int KEY_W = 65,
   parameter int ID_W  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kbt_pkg::cell_ctl_type ctl,
   input  logic [KEY_W-1:0]      new_key,
   input  logic [ID_W-1:0]       new_id,
   input  logic                  prev_lt,
   input  logic                  prev_valid,
   input  logic [KEY_W-1:0]      prev_key,
   input  logic [ID_W-1:0]       prev_id,
   input  logic                  next_valid,
   input  logic [KEY_W-1:0]      next_key,
   input  logic [ID_W-1:0]       next_id,
   output logic                  lt,
   output logic                  valid,
   output logic [KEY_W-1:0]      key,
   output logic [ID_W-1:0]       id
);
   import kbt_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [ID_W-1:0]  id_ff, id_in;

   // new key sorts ahead of this cell
   assign lt = !valid_ff || (new_key < key_ff);

   // insert shifts toward the tail, pop shifts toward the head
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      id_in    = id_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         valid_in = next_valid;
         key_in   = next_key;
         id_in    = next_id;
      end else if (ctl.ins && lt) begin
         if (prev_lt) begin
            valid_in = prev_valid;
            key_in   = prev_key;
            id_in    = prev_id;
         end else begin
            valid_in = 1'b1;
            key_in   = new_key;
            id_in    = new_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign id    = id_ff;

endmodule

@@ src/kbt_chain.sv @@
// row of sorting cells, smallest key at the head
// depends on kbt_pkg and kbt_cell
module kbt_chain #(
   parameter int DEPTH = 64,
   parameter int KEY_W = 65,
   parameter int ID_W  = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kbt_pkg::cell_ctl_type ctl,
   input  logic [KEY_W-1:0]      new_key,
   input  logic [ID_W-1:0]       new_id,
   output logic                  head_valid,
   output logic [KEY_W-1:0]      head_key,
   output logic [ID_W-1:0]       head_id,
   output logic                  second_valid
);
   import kbt_pkg::*;

   logic             lt_w    [DEPTH];
   logic             valid_w [DEPTH];
   logic [KEY_W-1:0] key_w   [DEPTH];
   logic [ID_W-1:0]  id_w    [DEPTH];

   // neighbor links between the cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic             p_lt, p_valid, n_valid;
      logic [KEY_W-1:0] p_key, n_key;
      logic [ID_W-1:0]  p_id, n_id;
      if (g == 0) begin : g_first
         assign p_lt    = 1'b0;
         assign p_valid = 1'b0;
         assign p_key   = '0;
         assign p_id    = '0;
      end else begin : g_mid
         assign p_lt    = lt_w[g-1];
         assign p_valid = valid_w[g-1];
         assign p_key   = key_w[g-1];
         assign p_id    = id_w[g-1];
      end
      if (g == DEPTH-1) begin : g_last
         assign n_valid = 1'b0;
         assign n_key   = '0;
         assign n_id    = '0;
      end else begin : g_inner
         assign n_valid = valid_w[g+1];
         assign n_key   = key_w[g+1];
         assign n_id    = id_w[g+1];
      end
      kbt_cell #(.KEY_W(KEY_W), .ID_W(ID_W)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .new_key(new_key), .new_id(new_id),
         .prev_lt(p_lt), .prev_valid(p_valid), .prev_key(p_key), .prev_id(p_id),
         .next_valid(n_valid), .next_key(n_key), .next_id(n_id),
         .lt(lt_w[g]), .valid(valid_w[g]), .key(key_w[g]), .id(id_w[g])
      );
   end

   assign head_valid = valid_w[0];
   assign head_key   = key_w[0];
   assign head_id    = id_w[0];
   if (DEPTH > 1) begin : g_second
      assign second_valid = valid_w[1];
   end else begin : g_nosecond
      assign second_valid = 1'b0;
   end

endmodule

@@ src/kbucket_routing_table.sv @@
// k-bucket routing table: IDs live in a table with a read and a write port, of
// ID_BITS rows of BUCKET_SIZE slots, row chosen by the highest set bit of the
// XOR distance to own_id. An add compares the entries of its row in turn and,
// when a contact goes to the head, moves each earlier entry back by one. A find
// reads every slot of the table once, one per cycle, through a 64-cell sorting
// chain keyed by own-row first and then distance; up to result_limit winners
// move into a second chain sorted by distance alone and leave as results, one
// per cycle unless the result channel stalls. There is no clearing pass:
// per-row fill counters reset to zero. One request is worked on at a time; a
// new one is taken once the previous last result is taken.
// depends on kbt_pkg and kbt_chain
module kbucket_routing_table #(
   parameter int ID_BITS     = kbt_pkg::DEF_ID_BITS,
   parameter int BUCKET_SIZE = kbt_pkg::DEF_BUCKET_SIZE
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [kbt_pkg::FIELD_W-1:0] csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [kbt_pkg::FIELD_W-1:0] req_node_id,
   input  logic                        req_contacted,
   input  logic [kbt_pkg::LIMIT_W-1:0] req_result_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_added,
   output logic [kbt_pkg::FIELD_W-1:0] rsp_found_id,
   output logic                        rsp_found_valid,
   output logic                        rsp_last
);
   import kbt_pkg::*;

   localparam int B_W    = $clog2(ID_BITS);
   localparam int BL_W   = $clog2(ID_BITS + 1);
   localparam int SLOT_W = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
   localparam int FILL_W = $clog2(BUCKET_SIZE + 1);
   localparam int ADDR_W = B_W + SLOT_W;
   localparam int DEPTH  = ID_BITS << SLOT_W;
   localparam int KEY_W  = ID_BITS + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_ADD, S_ASCAN, S_ACHK, S_AMOVE, S_AMOVW,
      S_FSCAN, S_FDRAIN, S_FSEL, S_FEMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [FIELD_W-1:0]   own_ff;
   logic                 func_ff, func_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic                 contacted_ff, contacted_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [B_W-1:0]       bucket_ff, bucket_in;
   logic                 self_ff, self_in;
   logic [FILL_W-1:0]    n_ff, n_in;
   logic [FILL_W-1:0]    idx_ff, idx_in;
   logic [B_W-1:0]       scan_b_ff, scan_b_in;
   logic [SLOT_W-1:0]    scan_i_ff, scan_i_in;
   logic                 tagv_ff, tagv_in;
   logic                 tagh_ff, tagh_in;
   logic [LIMIT_W-1:0]   cnt_ff, cnt_in;
   logic [FILL_W-1:0]    fill_ff [ID_BITS];
   logic                 fill_we;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_added_ff, rsp_added_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic                 rsp_fv_ff, rsp_fv_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [ID_BITS-1:0]   mem [DEPTH];
   logic [ID_BITS-1:0]   rd_ff;
   logic [ADDR_W-1:0]    mem_ra, mem_wa;
   logic                 mem_we;
   logic [ID_BITS-1:0]   mem_wd;

   logic [ID_BITS-1:0]   xo;
   logic [BL_W-1:0]      bl;
   logic                 slot_free;

   cell_ctl_type         c1_ctl, c2_ctl;
   logic [KEY_W-1:0]     c1_key, c2_key;
   logic                 c1_hv, c2_hv, c1_sv, c2_sv;
   logic [KEY_W-1:0]     c1_hk, c2_hk;
   logic [ID_BITS-1:0]   c1_hid, c2_hid;

   // slot index just ahead of the given one
   function automatic logic [SLOT_W-1:0] idx_in_prev(input logic [FILL_W-1:0] v);
      logic [FILL_W-1:0] d;
      d = v - FILL_W'(1);
      return d[SLOT_W-1:0];
   endfunction

   // highest set bit of the distance to own id
   assign xo = id_ff ^ own_ff[ID_BITS-1:0];
   always_comb begin
      bl = '0;
      for (int k = 0; k < ID_BITS; k++) begin
         if (xo[k]) begin
            bl = BL_W'(k + 1);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // selection chain: own row first, then distance
   assign c1_key = {!tagh_ff, rd_ff ^ id_ff};
   kbt_chain #(.DEPTH(MAX_OUT), .KEY_W(KEY_W), .ID_W(ID_BITS)) u_sel (
      .clock(clock), .reset(reset), .ctl(c1_ctl),
      .new_key(c1_key), .new_id(rd_ff),
      .head_valid(c1_hv), .head_key(c1_hk), .head_id(c1_hid), .second_valid(c1_sv)
   );

   // output chain: distance only
   assign c2_key = {1'b0, c1_hk[ID_BITS-1:0]};
   kbt_chain #(.DEPTH(MAX_OUT), .KEY_W(KEY_W), .ID_W(ID_BITS)) u_out (
      .clock(clock), .reset(reset), .ctl(c2_ctl),
      .new_key(c2_key), .new_id(c1_hid),
      .head_valid(c2_hv), .head_key(c2_hk), .head_id(c2_hid), .second_valid(c2_sv)
   );

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      contacted_in = contacted_ff;
      limit_in     = limit_ff;
      bucket_in    = bucket_ff;
      self_in      = self_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      scan_b_in    = scan_b_ff;
      scan_i_in    = scan_i_ff;
      tagv_in      = 1'b0;
      tagh_in      = 1'b0;
      cnt_in       = cnt_ff;
      fill_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_added_in = rsp_added_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_fv_in    = rsp_fv_ff;
      rsp_last_in  = rsp_last_ff;
      mem_ra       = {bucket_ff, idx_ff[SLOT_W-1:0]};
      mem_we       = 1'b0;
      mem_wa       = {bucket_ff, idx_ff[SLOT_W-1:0]};
      mem_wd       = id_ff;
      c1_ctl       = '{clear: 1'b0, ins: tagv_ff, pop: 1'b0};
      c2_ctl       = '{clear: 1'b0, ins: 1'b0, pop: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               func_in      = req_func;
               id_in        = req_node_id[ID_BITS-1:0];
               contacted_in = req_contacted;
               limit_in     = (req_result_limit > LIMIT_W'(MAX_OUT)) ?
                              LIMIT_W'(MAX_OUT) : req_result_limit;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            bucket_in = B_W'(bl - BL_W'(1));
            self_in   = (xo == '0);
            idx_in    = '0;
            scan_b_in = '0;
            scan_i_in = '0;
            c1_ctl.clear = 1'b1;
            c2_ctl.clear = 1'b1;
            state_in  = (func_ff == FUNC_ADD) ? S_ADD : S_FSCAN;
         end
         S_ADD: begin
            n_in = fill_ff[bucket_ff];
            if (self_ff) begin
               rsp_valid_in = 1'b1;
               rsp_added_in = 1'b0;
               rsp_id_in    = '0;
               rsp_fv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (idx_ff < n_ff) begin
               state_in = S_ACHK;
            end else begin
               // not present: append if there is room
               if (n_ff < FILL_W'(BUCKET_SIZE)) begin
                  mem_we  = 1'b1;
                  fill_we = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_added_in = (n_ff < FILL_W'(BUCKET_SIZE));
               rsp_id_in    = '0;
               rsp_fv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ACHK: begin
            if (rd_ff == id_ff) begin
               if (contacted_ff) begin
                  state_in = S_AMOVE;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_added_in = 1'b0;
                  rsp_id_in    = '0;
                  rsp_fv_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in   = idx_ff + FILL_W'(1);
               state_in = S_ASCAN;
            end
         end
         S_AMOVE: begin
            // shift earlier entries back by one, then put the id at the head
            if (idx_ff == '0) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_added_in = 1'b0;
               rsp_id_in    = '0;
               rsp_fv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               mem_ra   = {bucket_ff, idx_in_prev(idx_ff)};
               state_in = S_AMOVW;
            end
         end
         S_AMOVW: begin
            mem_we   = 1'b1;
            mem_wd   = rd_ff;
            idx_in   = idx_ff - FILL_W'(1);
            state_in = S_AMOVE;
         end
         S_FSCAN: begin
            // read one slot a cycle and tag it for the selection chain
            mem_ra    = {scan_b_ff, scan_i_ff};
            tagv_in   = (FILL_W'(scan_i_ff) < fill_ff[scan_b_ff]);
            tagh_in   = !self_ff && (scan_b_ff == bucket_ff);
            scan_i_in = scan_i_ff + SLOT_W'(1);
            if (scan_i_ff == '1) begin
               scan_b_in = scan_b_ff + B_W'(1);
               if (scan_b_ff == B_W'(ID_BITS - 1)) begin
                  state_in = S_FDRAIN;
               end
            end
         end
         S_FDRAIN: begin
            cnt_in   = '0;
            state_in = S_FSEL;
         end
         S_FSEL: begin
            if ((cnt_ff < limit_ff) && c1_hv) begin
               c1_ctl.pop = 1'b1;
               c2_ctl.ins = 1'b1;
               cnt_in     = cnt_ff + LIMIT_W'(1);
            end else begin
               state_in = S_FEMIT;
            end
         end
         S_FEMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_added_in = 1'b0;
               if (c2_hv) begin
                  rsp_id_in   = c2_hid;
                  rsp_fv_in   = 1'b1;
                  rsp_last_in = !c2_sv;
                  c2_ctl.pop  = 1'b1;
                  if (!c2_sv) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_id_in   = '0;
                  rsp_fv_in   = 1'b0;
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, registered outputs and fill counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         own_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tagv_ff      <= 1'b0;
         for (int k = 0; k < ID_BITS; k++) begin
            fill_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tagv_ff      <= tagv_in;
         if (csr_we) begin
            own_ff <= csr_wdata;
         end
         if (fill_we) begin
            fill_ff[bucket_ff] <= n_ff + FILL_W'(1);
         end
      end
      func_ff      <= func_in;
      id_ff        <= id_in;
      contacted_ff <= contacted_in;
      limit_ff     <= limit_in;
      bucket_ff    <= bucket_in;
      self_ff      <= self_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      scan_b_ff    <= scan_b_in;
      scan_i_ff    <= scan_i_in;
      tagh_ff      <= tagh_in;
      cnt_ff       <= cnt_in;
      rsp_added_ff <= rsp_added_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_fv_ff    <= rsp_fv_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // entry table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   assign req_ready       = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_added       = rsp_added_ff;
   assign rsp_found_id    = FIELD_W'(rsp_id_ff);
   assign rsp_found_valid = rsp_fv_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ src/kbt_checker.sv @@
// port-level checks for the routing table's result channel
// depends on kbt_pkg; bound to kbucket_routing_table
module kbt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_added,
   input logic [kbt_pkg::FIELD_W-1:0] rsp_found_id,
   input logic                        rsp_found_valid,
   input logic                        rsp_last
);
   import kbt_pkg::*;

   // a stalled result stays valid with its id and last flag held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_id) && $stable(rsp_last))
      else $error("result changed while stalled");

   // a result that reports an add is single and carries no contact
   a_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_added |-> !rsp_found_valid && rsp_last)
      else $error("add result malformed");

   // an empty result ends the request
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found_valid |-> rsp_last)
      else $error("empty result not last");

   // an empty result carries a zero id
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found_valid |-> rsp_found_id == '0)
      else $error("empty result with nonzero id");

endmodule

bind kbucket_routing_table kbt_checker u_kbt_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_added(rsp_added), .rsp_found_id(rsp_found_id),
   .rsp_found_valid(rsp_found_valid), .rsp_last(rsp_last)
);
